// ----- hdl/epp_pkg.sv -----
// epp_pkg: shared types and constants for the ellipse polygon block
// no dependencies
package epp_pkg;

    localparam int TURN_BITS    = 16;
    localparam int QUARTER_BITS = 14;
    localparam int COORD_W      = 20;
    localparam int OUT_W        = 21;
    localparam int SIN_W        = 17;   // signed q15, range -32768..32768
    localparam int HALF_PI_Q30  = 1686629713;

    // work item passed from the front end to the vertex engine
    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic [COORD_W-1:0]        axis_width;
        logic [COORD_W-1:0]        axis_height;
        logic [TURN_BITS-1:0]      rotation;
        logic [TURN_BITS-1:0]      angle_step;
        logic [6:0]                count;
    } t_job;

endpackage

// ----- hdl/epp_front.sv -----
// epp_front: input stage, clamps the step, counts vertices, queues jobs
// depends on epp_pkg
module epp_front #(
    parameter int MAX_POINTS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [19:0]            i_center_x,
    input  logic signed [19:0]            i_center_y,
    input  logic [19:0]                   i_axis_width,
    input  logic [19:0]                   i_axis_height,
    input  logic [15:0]                   i_rotation,
    input  logic [15:0]                   i_angle_step,
    output logic                          o_job_valid,
    input  logic                          i_job_ready,
    output epp_pkg::t_job                 o_job
);
    import epp_pkg::*;

    localparam int MIN_STEP = (65536 + MAX_POINTS - 1) / MAX_POINTS;

    // two-entry queue
    t_job        r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    t_job        w_job;
    logic [15:0] w_step;
    logic [6:0]  w_count;

    // count = ceil(65536/step): search k with (k-1)*step < 65536 <= k*step is
    // long, so compare k*step directly: smallest k from a small loop of thresholds
    always_comb begin
        w_step  = (i_angle_step < 16'(MIN_STEP)) ? 16'(MIN_STEP) : i_angle_step;
        w_count = 7'(MAX_POINTS);
        for (int k = MAX_POINTS; k >= 1; k--) begin
            // independent compares, priority picks the smallest k
            if (32'(w_step) * 32'(k) >= 32'd65536) w_count = 7'(k);
        end
        w_job.center_x    = i_center_x;
        w_job.center_y    = i_center_y;
        w_job.axis_width  = i_axis_width;
        w_job.axis_height = i_axis_height;
        w_job.rotation    = i_rotation;
        w_job.angle_step  = w_step;
        w_job.count       = w_count;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) r_q[r_wp] <= w_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_valid && o_ready) r_wp <= ~r_wp;
            if (o_job_valid && i_job_ready) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_valid && o_ready) - 2'(o_job_valid && i_job_ready);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
    a_count_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid |-> (o_job.count != 7'd0))
        else $error("zero vertex count queued");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !o_ready)
        else $error("accept while full");

endmodule

// ----- hdl/epp_engine.sv -----
// epp_engine: vertex engine, sine lookups, multiply pipeline, rounding and saturation
// depends on epp_pkg
module epp_engine #(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    output logic                  o_job_ready,
    input  epp_pkg::t_job         i_job,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [20:0]    o_point_x,
    output logic signed [20:0]    o_point_y,
    output logic [5:0]            o_point_index,
    output logic                  o_last_point
);
    import epp_pkg::*;

    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ROT  = 3'b010,
        S_RUN  = 3'b100
    } t_state;

    // constant q15 quarter-wave table, sin(i*pi/(2*depth)) by q30 taylor series,
    // rounded half up
    logic [16:0] w_sin_tab [SINE_TABLE_DEPTH+1];

    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_sin
        localparam longint unsigned X  = longint'(g) * longint'(HALF_PI_Q30)
                                         / longint'(SINE_TABLE_DEPTH);
        localparam longint unsigned T1 = ((((X * X) >> 30) * X) >> 30) / 64'd6;
        localparam longint unsigned T2 = ((((T1 * X) >> 30) * X) >> 30) / 64'd20;
        localparam longint unsigned T3 = ((((T2 * X) >> 30) * X) >> 30) / 64'd42;
        localparam longint unsigned T4 = ((((T3 * X) >> 30) * X) >> 30) / 64'd72;
        localparam longint unsigned T5 = ((((T4 * X) >> 30) * X) >> 30) / 64'd110;
        localparam longint unsigned T6 = ((((T5 * X) >> 30) * X) >> 30) / 64'd156;
        localparam longint unsigned T7 = ((((T6 * X) >> 30) * X) >> 30) / 64'd210;
        localparam longint S = longint'(X) - longint'(T1) + longint'(T2) - longint'(T3)
                               + longint'(T4) - longint'(T5) + longint'(T6) - longint'(T7);
        localparam longint R = (((S < 64'sd0) ? 64'sd0 : S) + 64'sd16384) >>> 15;
        assign w_sin_tab[g] = 17'((R > 64'sd32768) ? 64'sd32768 : R);
    end

    function automatic logic signed [16:0] sin_lut(input logic [15:0] a);
        logic [1:0]  quad;
        logic [13:0] q;
        logic [14:0] r;
        logic [IDX_W+14:0] p;
        logic [IDX_W-1:0] idx;
        logic [16:0] v;
        quad = a[15:14];
        q    = a[13:0];
        r    = quad[0] ? (15'd16384 - 15'(q)) : 15'(q);
        p    = (IDX_W+15)'(r) * (IDX_W+15)'(SINE_TABLE_DEPTH);
        idx  = IDX_W'(p >> 14);
        v    = w_sin_tab[idx];
        return quad[1] ? -$signed(v) : $signed(v);
    endfunction

    t_state r_state;
    t_job   r_job;
    logic signed [16:0] r_ct, r_st;
    logic [15:0] r_t;
    logic [6:0]  r_k;

    // pipeline stage 1: table values
    logic        r1_v, r1_last;
    logic [5:0]  r1_k;
    logic signed [16:0] r1_c, r1_s;
    // stage 2: axis products
    logic        r2_v, r2_last;
    logic [5:0]  r2_k;
    logic signed [37:0] r2_wc, r2_hs;
    // stage 3: rotated products
    logic        r3_v, r3_last;
    logic [5:0]  r3_k;
    logic signed [55:0] r3_a, r3_b, r3_c, r3_d;
    // stage 4: sums, rounded
    logic        r4_v, r4_last;
    logic [5:0]  r4_k;
    logic signed [25:0] r4_dx, r4_dy;
    // output register
    logic        r_ov;

    logic        w_adv;
    logic        w_issue;
    logic        w_load;
    logic [3:0]  w_inflight;
    logic signed [56:0] w_sx, w_sy;
    logic signed [26:0] w_px, w_py;

    // pipeline moves as a whole when the output is free
    assign w_adv   = !r_ov || i_ready;
    assign w_issue = (r_state == S_RUN) && w_adv;
    // a new job only once the previous one has left the multiply stages
    assign o_job_ready = (r_state == S_IDLE) && (w_inflight == 4'd0);
    assign w_load      = i_job_valid && o_job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (w_load) r_state <= S_ROT;
                S_ROT:  r_state <= S_RUN;
                S_RUN: begin
                    if (w_issue) begin
                        r_k <= r_k + 7'd1;
                        if (r_k + 7'd1 == r_job.count) begin
                            r_state <= S_IDLE;
                            r_k     <= '0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_job <= i_job;
            r_t   <= '0;
        end
        if (r_state == S_ROT) begin
            r_ct <= sin_lut(r_job.rotation + 16'd16384);
            r_st <= sin_lut(r_job.rotation);
        end
        if (w_issue) r_t <= r_t + r_job.angle_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0; r4_v <= 1'b0; r_ov <= 1'b0;
        end else if (w_adv) begin
            r1_v <= w_issue;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r_ov <= r4_v;
        end
    end

    always_comb begin
        w_sx = 57'(r3_a) - 57'(r3_b) + 57'sd1073741824;
        w_sy = 57'(r3_c) + 57'(r3_d) + 57'sd1073741824;
    end

    always_comb begin
        w_px = 27'(r4_dx) + 27'($signed(r_job.center_x));
        w_py = 27'(r4_dy) + 27'($signed(r_job.center_y));
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_c    <= sin_lut(r_t + 16'd16384);
            r1_s    <= sin_lut(r_t);
            r1_k    <= r_k[5:0];
            r1_last <= (r_k + 7'd1 == r_job.count);
            r2_wc   <= $signed({1'b0, r_job.axis_width}) * r1_c;
            r2_hs   <= $signed({1'b0, r_job.axis_height}) * r1_s;
            r2_k    <= r1_k;
            r2_last <= r1_last;
            r3_a    <= r2_wc * r_ct;
            r3_b    <= r2_hs * r_st;
            r3_c    <= r2_wc * r_st;
            r3_d    <= r2_hs * r_ct;
            r3_k    <= r2_k;
            r3_last <= r2_last;
            r4_dx   <= 26'(w_sx >>> 31);
            r4_dy   <= 26'(w_sy >>> 31);
            r4_k    <= r3_k;
            r4_last <= r3_last;
            o_point_x     <= (w_px > 27'sd1048575) ? 21'sd1048575 :
                             (w_px < -27'sd1048576) ? -21'sd1048576 : 21'(w_px);
            o_point_y     <= (w_py > 27'sd1048575) ? 21'sd1048575 :
                             (w_py < -27'sd1048576) ? -21'sd1048576 : 21'(w_py);
            o_point_index <= r4_k;
            o_last_point  <= r4_last;
        end
    end

    assign o_valid    = r_ov;
    assign w_inflight = 4'(r1_v) + 4'(r2_v) + 4'(r3_v) + 4'(r4_v);

    a_idle_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT) |-> !r1_v)
        else $error("rotation load while first stage busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_point_index))
        else $error("output changed under stall");
    a_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_inflight <= 4'd4)
        else $error("pipeline count");

endmodule

// ----- hdl/ellipse_polygon_points.sv -----
// ellipse_polygon_points: rotated ellipse to polygon vertices, front queue plus vertex engine
// depends on epp_pkg, epp_front, epp_engine
// flow: jobs are queued, loaded, take rotation sine and cosine, then give one vertex per cycle
//   while the receiver is ready; ceil(65536/step) vertices (at most MAX_POINTS) per ellipse; the
//   multiply pipeline drains before the next job is loaded and its rotation sine and cosine read
// reset: synchronous active low, clears queue pointers, state and valid bits
module ellipse_polygon_points #(
    parameter int MAX_POINTS       = 64,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [19:0]  i_center_x,
    input  logic signed [19:0]  i_center_y,
    input  logic [19:0]         i_axis_width,
    input  logic [19:0]         i_axis_height,
    input  logic [15:0]         i_rotation,
    input  logic [15:0]         i_angle_step,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [20:0]  o_point_x,
    output logic signed [20:0]  o_point_y,
    output logic [5:0]          o_point_index,
    output logic                o_last_point
);
    import epp_pkg::*;

    // job transaction between front and engine
    logic w_job_valid;
    logic w_job_ready;
    t_job w_job;

    epp_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_center_x(i_center_x), .i_center_y(i_center_y),
        .i_axis_width(i_axis_width), .i_axis_height(i_axis_height),
        .i_rotation(i_rotation), .i_angle_step(i_angle_step),
        .o_job_valid(w_job_valid), .i_job_ready(w_job_ready), .o_job(w_job)
    );

    epp_engine #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(w_job_valid), .o_job_ready(w_job_ready), .i_job(w_job),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_point_x(o_point_x), .o_point_y(o_point_y),
        .o_point_index(o_point_index), .o_last_point(o_last_point)
    );

endmodule

// ----- verif/tb_ellipse_polygon_points.sv -----
// tb_ellipse_polygon_points: self-checking bench for the ellipse to polygon vertex block
// depends on epp_pkg and ellipse_polygon_points; builds its own sine table and vertex predictor
module tb_ellipse_polygon_points;
    timeunit 1ns;
    timeprecision 1ps;

    import epp_pkg::*;

    localparam int MAX_PTS   = 64;
    localparam int TAB_DEPTH = 256;
    localparam int MIN_STEP  = (65536 + MAX_PTS - 1) / MAX_PTS;
    localparam longint OUT_MAX = 1048575;
    localparam longint OUT_MIN = -1048576;

    typedef struct {
        logic signed [20:0] px;
        logic signed [20:0] py;
        logic [5:0]         idx;
        logic               last;
    } t_vertex;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [19:0] i_center_x = '0;
    logic signed [19:0] i_center_y = '0;
    logic [19:0]        i_axis_width = '0;
    logic [19:0]        i_axis_height = '0;
    logic [15:0]        i_rotation = '0;
    logic [15:0]        i_angle_step = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [20:0] o_point_x;
    logic signed [20:0] o_point_y;
    logic [5:0]         o_point_index;
    logic               o_last_point;

    ellipse_polygon_points #(.MAX_POINTS(MAX_PTS), .SINE_TABLE_DEPTH(TAB_DEPTH)) dut (.*);

    always #4 i_clk = ~i_clk;

    // own quarter-wave table, q15
    longint  sin_tab [0:TAB_DEPTH];
    t_vertex vertex_q[$];
    int      fail_count = 0;
    int      send_idle_pct = 20;
    int      recv_idle_pct = 20;
    int      recv_hold = 0;

    function automatic longint build_entry(int i);
        longint unsigned x, term;
        longint sum;
        x = longint'(i) * 64'd1686629713 / TAB_DEPTH;
        term = x;
        sum = longint'(x);
        for (int k = 1; k <= 7; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / ((2 * k) * (2 * k + 1));
            if (k % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
        end
        if (sum < 0) sum = 0;
        sum = (sum + 16384) >>> 15;
        if (sum > 32768) sum = 32768;
        return sum;
    endfunction

    function automatic longint wave_sin(int unsigned a);
        int unsigned quad, q, r, ix;
        quad = (a >> 14) & 3;
        q = a & 16383;
        r = quad[0] ? 16384 - q : q;
        ix = (r * TAB_DEPTH) >> 14;
        if (ix > TAB_DEPTH) ix = TAB_DEPTH;
        return quad[1] ? -sin_tab[ix] : sin_tab[ix];
    endfunction

    function automatic longint wave_cos(int unsigned a);
        return wave_sin((a + 16384) & 65535);
    endfunction

    // round half up by 2^31, then saturate onto the centre
    function automatic logic signed [20:0] place(longint centre, longint off);
        longint v;
        v = centre + ((off + (64'sd1 <<< 30)) >>> 31);
        if (v > OUT_MAX) v = OUT_MAX;
        if (v < OUT_MIN) v = OUT_MIN;
        return v[20:0];
    endfunction

    task automatic predict_vertices(logic signed [19:0] cx, logic signed [19:0] cy,
                                    logic [19:0] w, logic [19:0] h,
                                    logic [15:0] th, logic [15:0] st_in);
        int unsigned st, cnt, t;
        longint ct, sn, c, s, dx, dy;
        t_vertex v;
        st = st_in < MIN_STEP ? MIN_STEP : st_in;
        cnt = (65536 + st - 1) / st;
        if (cnt > MAX_PTS) cnt = MAX_PTS;
        ct = wave_cos(th);
        sn = wave_sin(th);
        for (int unsigned k = 0; k < cnt; k++) begin
            t = (k * st) & 65535;
            c = wave_cos(t);
            s = wave_sin(t);
            dx = longint'(w) * c * ct - longint'(h) * s * sn;
            dy = longint'(w) * c * sn + longint'(h) * s * ct;
            v.px = place(longint'(cx), dx);
            v.py = place(longint'(cy), dy);
            v.idx = k[5:0];
            v.last = (k + 1 == cnt);
            vertex_q.insert(vertex_q.size(), v);
        end
    endtask

    // one ellipse transaction, with random idle beforehand
    task automatic send_ellipse(logic signed [19:0] cx, logic signed [19:0] cy,
                                logic [19:0] w, logic [19:0] h,
                                logic [15:0] th, logic [15:0] st);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_center_x <= cx;
        i_center_y <= cy;
        i_axis_width <= w;
        i_axis_height <= h;
        i_rotation <= th;
        i_angle_step <= st;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_vertices(cx, cy, w, h, th, st);
    endtask

    task automatic send_random(int pct_small_step);
        logic [15:0] st;
        st = ($urandom_range(99) < pct_small_step) ? 16'($urandom_range(1500))
                                                   : 16'($urandom);
        send_ellipse(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
                     16'($urandom), st);
    endtask

    task automatic drain_all();
        i_valid <= 1'b0;
        while (vertex_q.size() != 0) @(posedge i_clk);
    endtask

    // extremes of every field and the special cases
    task automatic test_directed();
        send_ellipse(20'sd0, 20'sd0, 20'd0, 20'd0, 16'd0, 16'd0);          // zero step
        send_ellipse(20'sd100, -20'sd100, 20'd320, 20'd160, 16'd0, 16'd1023);
        send_ellipse(20'sd0, 20'sd0, 20'd1000, 20'd500, 16'd8192, 16'd1024);
        send_ellipse(20'sd0, 20'sd0, 20'd1000, 20'd500, 16'd16384, 16'd16384);
        send_ellipse(20'sd0, 20'sd0, 20'd1000, 20'd500, 16'd32768, 16'd21846);
        send_ellipse(20'sd0, 20'sd0, 20'd3, 20'd1, 16'd49152, 16'd65535); // two vertices
        send_ellipse(20'sd0, 20'sd0, 20'd3, 20'd3, 16'd65535, 16'd32768);
        send_ellipse(20'sd0, 20'sd0, 20'd1, 20'd1, 16'd1234, 16'd4097);   // rounding halves
        // saturation on both sides
        send_ellipse(20'sh7FFFF, 20'sh7FFFF, 20'hFFFFF, 20'hFFFFF, 16'd0, 16'd4096);
        send_ellipse(-20'sh80000, -20'sh80000, 20'hFFFFF, 20'hFFFFF, 16'd8192, 16'd4096);
        send_ellipse(-20'sh80000, 20'sh7FFFF, 20'hFFFFF, 20'd0, 16'hFFFF, 16'd2048);
        send_ellipse(20'sh55555, -20'sh2AAAB, 20'hAAAAA, 20'h55555, 16'hAAAA, 16'h5555);
        drain_all();
    endtask

    // receiver holds off while the sender keeps going, so the block backs up
    task automatic test_backpressure();
        recv_hold = 400;
        repeat (6) send_random(30);
        drain_all();
    endtask

    task automatic test_random();
        for (int n = 0; n < 92; n++) begin
            // a calm stretch with no idling on either side
            send_idle_pct = (n >= 40 && n < 55) ? 0 : 20;
            recv_idle_pct = send_idle_pct;
            send_random(25);
        end
        send_idle_pct = 20;
        recv_idle_pct = 20;
        drain_all();
    endtask

    // result side: random idling, optional long hold-off
    always @(posedge i_clk) begin
        if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // compare every vertex transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_vertex e;
        if (i_rst_n && o_valid && i_ready) begin
            if (vertex_q.size() == 0) begin
                $display("%0t: unexpected vertex x=%0d y=%0d idx=%0d", $time,
                         o_point_x, o_point_y, o_point_index);
                fail_count++;
            end else begin
                e = vertex_q.pop_front();
                if (o_point_x !== e.px || o_point_y !== e.py ||
                    o_point_index !== e.idx || o_last_point !== e.last) begin
                    $display("%0t: vertex mismatch exp x=%0d y=%0d idx=%0d last=%0b",
                             $time, e.px, e.py, e.idx, e.last);
                    $display("%0t:                 got x=%0d y=%0d idx=%0d last=%0b",
                             $time, o_point_x, o_point_y, o_point_index, o_last_point);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i <= TAB_DEPTH; i++) sin_tab[i] = build_entry(i);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && vertex_q.size() == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end
endmodule

// ----- ellipse_polygon_points.f -----
hdl/epp_pkg.sv
hdl/epp_front.sv
hdl/epp_engine.sv
hdl/ellipse_polygon_points.sv
verif/tb_ellipse_polygon_points.sv
